// ===== hw/rtl/dntw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntw_pkg
// shared types, tile codes and the one-digit split used by the converter
// ----------------------------------------------------------------------------
package dntw_pkg;

    localparam logic [7:0]  TILE_DIGIT0   = 8'h30;
    localparam logic [7:0]  TILE_BLANK    = 8'hFF;
    localparam logic [15:0] BASE_RESET    = 16'h2000;
    localparam int          NUM_DIGITS    = 5;
    localparam int          CNT_W         = 3;

    // command word
    typedef struct packed {
        logic [9:0]  position;
        logic [15:0] number;
        logic [5:0]  field_width;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [15:0] vram_address;
        logic [7:0]  tile;
        logic        last;
    } result_t;

    // decimal digits, index 0 is the ones digit
    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [16:0] rem;
    } split_t;

    // one decimal digit by compare against the nine multiples of the power
    function automatic split_t digit_split(input logic [16:0] rem, input logic [16:0] power);
        split_t r;
        logic [16:0] mult;
        r.digit = 4'd0;
        r.rem   = rem;
        for (int k = 1; k < 10; k++)
        begin
            mult = 17'(k) * power;
            if (rem >= mult)
            begin
                r.digit = 4'(k);
                r.rem   = rem - mult;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/dntw_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntw_convert
// five-stage pipeline: address and width, then a digit or two per stage
// ----------------------------------------------------------------------------
module dntw_convert #(
    parameter int MAX_WIDTH = 32,
    parameter int PAD_W     = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  dntw_pkg::cmd_t           in_word,
    input  logic [15:0]              base_address,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              out_addr,
    output dntw_pkg::digits_t        out_digits,
    output logic [dntw_pkg::CNT_W-1:0] out_cnt,
    output logic [PAD_W-1:0]         out_pad
);

    // stage valid bits
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s0_ready, s1_ready, s2_ready, s3_ready, s4_ready;

    // stage 0: raw command
    dntw_pkg::cmd_t s0_cmd_reg;

    // stage 1..3: address, clamped width, digits so far, remainder
    logic [15:0]       s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [PAD_W-1:0]  s1_w_reg, s2_w_reg, s3_w_reg;
    dntw_pkg::digits_t s1_dig_reg, s2_dig_reg, s3_dig_reg;
    logic [13:0]       s1_rem_reg;
    logic [9:0]        s2_rem_reg;
    logic [6:0]        s3_rem_reg;

    // stage 4: handoff to emitter
    logic [15:0]                  s4_addr_reg;
    dntw_pkg::digits_t            s4_dig_reg;
    logic [dntw_pkg::CNT_W-1:0]   s4_cnt_reg;
    logic [PAD_W-1:0]             s4_pad_reg;

    logic [15:0]                  s1_addr_next;
    logic [PAD_W-1:0]             s1_w_next;
    dntw_pkg::split_t             sp1, sp2, sp3, sp4;
    logic [dntw_pkg::CNT_W-1:0]   s4_cnt_next;
    logic [PAD_W-1:0]             s4_pad_next;
    logic [PAD_W-1:0]             w_ext;
    dntw_pkg::digits_t            s4_dig_next;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    // stage 0 -> 1
    always_comb
    begin
        s1_addr_next = base_address + {6'd0, s0_cmd_reg.position};
        w_ext        = PAD_W'(s0_cmd_reg.field_width);
        if (w_ext > PAD_W'(MAX_WIDTH))
            s1_w_next = PAD_W'(MAX_WIDTH);
        else
            s1_w_next = w_ext;
        sp1 = dntw_pkg::digit_split({1'b0, s0_cmd_reg.number}, 17'd10000);
    end

    // stage 1 -> 4 digit splits
    always_comb
    begin
        sp2 = dntw_pkg::digit_split({3'd0, s1_rem_reg}, 17'd1000);
        sp3 = dntw_pkg::digit_split({7'd0, s2_rem_reg}, 17'd100);
        sp4 = dntw_pkg::digit_split({10'd0, s3_rem_reg}, 17'd10);
    end

    // stage 3 -> 4: last digits, digit count, padding
    always_comb
    begin
        s4_dig_next    = s3_dig_reg;
        s4_dig_next[1] = sp4.digit;
        s4_dig_next[0] = sp4.rem[3:0];
        if (s3_dig_reg[4] != 4'd0)
            s4_cnt_next = 3'd5;
        else if (s3_dig_reg[3] != 4'd0)
            s4_cnt_next = 3'd4;
        else if (s3_dig_reg[2] != 4'd0)
            s4_cnt_next = 3'd3;
        else if (sp4.digit != 4'd0)
            s4_cnt_next = 3'd2;
        else
            s4_cnt_next = 3'd1;
        // zero width falls out as no padding
        if (s3_w_reg > PAD_W'(s4_cnt_next))
            s4_pad_next = s3_w_reg - PAD_W'(s4_cnt_next);
        else
            s4_pad_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready) s0_valid_reg <= in_valid;
            if (s1_ready) s1_valid_reg <= s0_valid_reg;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready)
            s0_cmd_reg <= in_word;
        if (s1_ready)
        begin
            s1_addr_reg   <= s1_addr_next;
            s1_w_reg      <= s1_w_next;
            s1_dig_reg    <= {sp1.digit, 16'd0};
            s1_rem_reg    <= sp1.rem[13:0];
        end
        if (s2_ready)
        begin
            s2_addr_reg   <= s1_addr_reg;
            s2_w_reg      <= s1_w_reg;
            s2_dig_reg    <= {s1_dig_reg[4], sp2.digit, s1_dig_reg[2:0]};
            s2_rem_reg    <= sp2.rem[9:0];
        end
        if (s3_ready)
        begin
            s3_addr_reg   <= s2_addr_reg;
            s3_w_reg      <= s2_w_reg;
            s3_dig_reg    <= {s2_dig_reg[4], s2_dig_reg[3], sp3.digit, s2_dig_reg[1:0]};
            s3_rem_reg    <= sp3.rem[6:0];
        end
        if (s4_ready)
        begin
            s4_addr_reg <= s3_addr_reg;
            s4_dig_reg  <= s4_dig_next;
            s4_cnt_reg  <= s4_cnt_next;
            s4_pad_reg  <= s4_pad_next;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign out_addr   = s4_addr_reg;
    assign out_digits = s4_dig_reg;
    assign out_cnt    = s4_cnt_reg;
    assign out_pad    = s4_pad_reg;

endmodule

// ===== hw/rtl/dntw_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntw_emit
// tile write sequencer: blanks then digits, one registered word per cycle
// ----------------------------------------------------------------------------
module dntw_emit #(
    parameter int PAD_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [15:0]                in_addr,
    input  dntw_pkg::digits_t          in_digits,
    input  logic [dntw_pkg::CNT_W-1:0] in_cnt,
    input  logic [PAD_W-1:0]           in_pad,
    output logic                       out_strobe,
    output dntw_pkg::result_t          out_word
);

    logic                        em_valid_reg, em_valid_next;
    logic [15:0]                 em_addr_reg, em_addr_next;
    logic [PAD_W-1:0]            em_pad_reg, em_pad_next;
    logic [dntw_pkg::CNT_W-1:0]  em_cnt_reg, em_cnt_next;
    dntw_pkg::digits_t           em_dig_reg, em_dig_next;
    logic                        strobe_reg, strobe_next;
    dntw_pkg::result_t           word_reg, word_next;

    logic                        cur_last;
    logic [dntw_pkg::CNT_W-1:0]  dig_idx;

    assign cur_last = (em_pad_reg == '0) && (em_cnt_reg == 3'd1);
    assign in_ready = !em_valid_reg || cur_last;
    assign dig_idx  = em_cnt_reg - 3'd1;

    always_comb
    begin
        em_valid_next = em_valid_reg;
        em_addr_next  = em_addr_reg;
        em_pad_next   = em_pad_reg;
        em_cnt_next   = em_cnt_reg;
        em_dig_next   = em_dig_reg;
        strobe_next   = em_valid_reg;
        word_next     = word_reg;
        if (em_valid_reg)
        begin
            word_next.vram_address = em_addr_reg;
            word_next.last         = cur_last;
            if (em_pad_reg != '0)
            begin
                word_next.tile = dntw_pkg::TILE_BLANK;
                em_pad_next    = em_pad_reg - PAD_W'(1);
            end
            else
            begin
                word_next.tile = dntw_pkg::TILE_DIGIT0 + {4'd0, em_dig_reg[dig_idx]};
                em_cnt_next    = em_cnt_reg - 3'd1;
            end
            em_addr_next = em_addr_reg + 16'd1;
        end
        if (in_ready)
        begin
            em_valid_next = in_valid;
            em_addr_next  = in_addr;
            em_pad_next   = in_pad;
            em_cnt_next   = in_cnt;
            em_dig_next   = in_digits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_addr_reg <= em_addr_next;
        em_pad_reg  <= em_pad_next;
        em_cnt_reg  <= em_cnt_next;
        em_dig_reg  <= em_dig_next;
        word_reg    <= word_next;
    end

    assign out_strobe = strobe_reg;
    assign out_word   = word_reg;

endmodule

// ===== hw/rtl/decimal_number_tile_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_tile_writer
// prints an unsigned 16-bit number as right-aligned decimal tiles
// ----------------------------------------------------------------------------
// A command (position, number, field_width) is taken on a clock edge where
// start is high and busy is low. It produces max(digit count, width) tile
// writes, width clamped to MAX_WIDTH and zero meaning the digit count: blank
// tiles (0xFF) first, then the digits (0x30 + digit), most significant
// first, at consecutive addresses from base_address + position, wrapping at
// 16 bits. Each word is shown for exactly one cycle with result_valid high
// and must be taken then: the receiver cannot hold words off. The first word
// of a command passes through the five converter stages, the sequencer's
// command registers and its output register. The tile sequencer emits
// one word per cycle for each command, 1 to MAX_WIDTH words; the five-stage
// converter ahead of it keeps up to five more commands, and busy rises
// when that queue is full and the sequencer cannot take the next one.
// base_address resets to 0x2000 and is written through cfg_valid/cfg_data,
// which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module decimal_number_tile_writer #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  dntw_pkg::cmd_t      cmd,
    // result side
    output logic                result_valid,
    output dntw_pkg::result_t   result,
    // base address register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    // pad counter wide enough for the clamped width and the raw field
    localparam int PAD_W = ($clog2(MAX_WIDTH + 1) > 6) ? $clog2(MAX_WIDTH + 1) : 6;

    logic [15:0]                base_address_reg;
    logic                       cmd_ready;

    // converter to sequencer handoff
    logic                       conv_valid;
    logic                       conv_ready;
    logic [15:0]                conv_addr;
    dntw_pkg::digits_t          conv_digits;
    logic [dntw_pkg::CNT_W-1:0] conv_cnt;
    logic [PAD_W-1:0]           conv_pad;

    // register write is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_address_reg <= dntw_pkg::BASE_RESET;
        else if (cfg_valid && cfg_ready)
            base_address_reg <= cfg_data;
    end

    // busy is back-pressure from the converter pipeline
    assign busy = !cmd_ready;

    dntw_convert #(
        .MAX_WIDTH (MAX_WIDTH),
        .PAD_W     (PAD_W)
    ) u_convert (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .in_ready     (cmd_ready),
        .in_word      (cmd),
        .base_address (base_address_reg),
        .out_valid    (conv_valid),
        .out_ready    (conv_ready),
        .out_addr     (conv_addr),
        .out_digits   (conv_digits),
        .out_cnt      (conv_cnt),
        .out_pad      (conv_pad)
    );

    dntw_emit #(
        .PAD_W (PAD_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (conv_valid),
        .in_ready   (conv_ready),
        .in_addr    (conv_addr),
        .in_digits  (conv_digits),
        .in_cnt     (conv_cnt),
        .in_pad     (conv_pad),
        .out_strobe (result_valid),
        .out_word   (result)
    );

`ifndef SYNTHESIS
    // a command's words come out without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a command's tile writes");

    // addresses step by one within a command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last
        |=> result.vram_address == $past(result.vram_address) + 16'd1)
        else $error("tile address did not advance by one");

    // no blank after a digit within a command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last && result.tile != dntw_pkg::TILE_BLANK
        |=> result.tile != dntw_pkg::TILE_BLANK)
        else $error("blank tile after a digit");

    // a command's last word is always a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.tile != dntw_pkg::TILE_BLANK)
        else $error("last tile is a blank");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the decimal number tile writer
// ----------------------------------------------------------------------------
// Commands go in through start/busy. Every accepted command is expanded
// into its expected tile writes: blanks first, then the digits, most
// significant first, at consecutive wrapping addresses. Each strobed result
// word is compared field by field with the oldest expected write. The base
// address register is rewritten between phases, only once the block has
// drained. A short directed part is followed by random phases at several
// base addresses.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FIELD_MAX     = 32;    // clamp for the field width
    localparam int SETTLE_CYCLES = 10;    // quiet margin once every expected word is back
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS   = 95;    // random commands per base setting

    // ------------------------------------------------------------------------
    // expected tile writes, built from each accepted command
    // ------------------------------------------------------------------------
    class tile_write_tracker;
        logic [15:0]       base_address;
        dntw_pkg::result_t expected_writes[$];
        int                errors;
        int                checked;

        function new();
            base_address = dntw_pkg::BASE_RESET;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_base(logic [15:0] value);
            base_address = value;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // split into decimal digits, clamp the width, then queue the writes
        function void note_command(dntw_pkg::cmd_t c);
            logic [3:0]        digs[dntw_pkg::NUM_DIGITS];
            int                value;
            int                ndig;
            int                width;
            int                pad;
            int                total;
            logic [15:0]       addr;
            dntw_pkg::result_t w;
            value = int'(c.number);
            ndig  = 0;
            if (value == 0)
            begin
                digs[0] = 4'd0;
                ndig    = 1;
            end
            else
            begin
                while (value > 0)
                begin
                    digs[ndig] = 4'(value % 10);
                    value      = value / 10;
                    ndig++;
                end
            end
            width = int'(c.field_width);
            if (width > FIELD_MAX)
                width = FIELD_MAX;
            if (width == 0)
                width = ndig;
            pad   = (width > ndig) ? width - ndig : 0;
            total = pad + ndig;
            addr  = base_address + 16'(c.position);
            for (int k = 0; k < total; k++)
            begin
                w.vram_address = addr;
                if (k < pad)
                    w.tile = dntw_pkg::TILE_BLANK;
                else
                    w.tile = dntw_pkg::TILE_DIGIT0 + 8'(digs[ndig - 1 - (k - pad)]);
                w.last = (k == total - 1);
                expected_writes.push_back(w);
                addr = addr + 16'd1;
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch on write %0d: %s got 0x%0h expected 0x%0h",
                     checked, what, got, want);
        endtask

        task check_write(dntw_pkg::result_t r);
            dntw_pkg::result_t want;
            if (expected_writes.size() == 0)
            begin
                report_mismatch("unexpected word, address", int'(r.vram_address), 0);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (r.vram_address !== want.vram_address)
                    report_mismatch("vram_address", int'(r.vram_address),
                                    int'(want.vram_address));
                if (r.tile !== want.tile)
                    report_mismatch("tile", int'(r.tile), int'(want.tile));
                if (r.last !== want.last)
                    report_mismatch("last", int'(r.last), int'(want.last));
            end
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    dntw_pkg::cmd_t    cmd;
    logic              result_valid;
    dntw_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              [15:0] cfg_data;

    decimal_number_tile_writer #(
        .MAX_WIDTH (FIELD_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    tile_write_tracker tracker = new();

    // coverage tallies for the closing summary
    int n_commands  = 0;
    int n_writes    = 0;
    int n_settings  = 0;
    int n_clamped   = 0;
    int n_narrow    = 0;
    int stall_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the block's
    // own updates land, so handshakes are seen exactly as the block sees them
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                tracker.note_command(cmd);
                n_commands++;
                if (cmd.field_width > FIELD_MAX)
                    n_clamped++;
                if (cmd.field_width != 0 && cmd.field_width < 5 && cmd.number >= 10000)
                    n_narrow++;
            end
            if (result_valid)
            begin
                tracker.check_write(result);
                n_writes++;
            end
            if (cfg_valid && cfg_ready)
            begin
                tracker.set_base(cfg_data);
                n_settings++;
            end
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d writes outstanding", tracker.pending());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // hold one command word until the block takes it; optionally idle after
    task send_command(input logic [9:0] pos, input logic [15:0] num,
                      input logic [5:0] width, input bit may_idle);
        dntw_pkg::cmd_t c;
        c.position    = pos;
        c.number      = num;
        c.field_width = width;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        // idle cycles carry junk on the command bus, never accepted
        if (may_idle)
        begin
            while ($urandom_range(99) < 24)
            begin
                start <= 1'b0;
                cmd   <= dntw_pkg::cmd_t'($urandom);
                @(posedge clk);
            end
        end
    endtask

    // sender holds off until every expected word is back, plus the pipeline;
    // it first lets the monitor note the last accepted command
    task wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // base address write, only issued once the block is idle
    task write_base(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // numbers spread over every digit count, extremes included
    function automatic logic [15:0] pick_number();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 9));
            3:       return 16'($urandom_range(10, 99));
            4:       return 16'($urandom_range(100, 999));
            5:       return 16'($urandom_range(1000, 9999));
            6:       return 16'($urandom_range(10000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short fields; some long, some above the clamp
    function automatic logic [5:0] pick_width();
        case ($urandom_range(9))
            0:       return 6'd0;
            1, 2, 3: return 6'($urandom_range(1, 8));
            4:       return 6'($urandom_range(0, 5));
            5:       return 6'($urandom_range(9, 32));
            6:       return 6'($urandom_range(33, 63));
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_position();
        case ($urandom_range(7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    logic [15:0] phase_bases[4];

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, base at its reset value
        send_command(10'd0,    16'd0,     6'd0,  1'b0);  // zero, width from digit count
        send_command(10'd1023, 16'hFFFF,  6'd0,  1'b0);  // five digits, top position
        send_command(10'd5,    16'hFFFF,  6'd5,  1'b0);  // exact fit
        send_command(10'd0,    16'd9,     6'd1,  1'b0);
        send_command(10'd0,    16'd10,    6'd1,  1'b0);  // narrow field, all digits kept
        send_command(10'd0,    16'd12345, 6'd3,  1'b0);  // narrow field
        send_command(10'd0,    16'd0,     6'd32, 1'b0);  // widest legal field
        send_command(10'd0,    16'd1,     6'd63, 1'b0);  // clamped to the max
        send_command(10'd0,    16'd42,    6'd33, 1'b0);  // just over the max
        send_command(10'd0,    16'd99,    6'd2,  1'b0);
        send_command(10'd0,    16'd999,   6'd6,  1'b0);
        send_command(10'd0,    16'd9999,  6'd4,  1'b0);
        send_command(10'd0,    16'd10000, 6'd0,  1'b0);
        send_command(10'd512,  16'd100,   6'd6,  1'b0);
        send_command(10'd1,    16'd7,     6'd63, 1'b0);

        // address wrap near the top of memory
        write_base(16'hFFF0);
        send_command(10'd0,    16'hFFFF,  6'd32, 1'b0);  // runs through 0xFFFF to 0
        send_command(10'd15,   16'd5,     6'd3,  1'b0);
        send_command(10'd1023, 16'd31337, 6'd0,  1'b0);

        // random phases; the second runs without any sender idling
        phase_bases[0] = 16'h0000;
        phase_bases[1] = 16'hFFFF;
        phase_bases[2] = 16'($urandom);
        phase_bases[3] = dntw_pkg::BASE_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_base(phase_bases[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender stops and waits for the pipeline to empty mid-phase
                if (p == 0 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_command(pick_position(), pick_number(), pick_width(), p != 1);
            end
        end

        // let every expected word come back, then a quiet settling margin
        wait_drained();

        $display("covered %0d commands, %0d tile writes, %0d base settings",
                 n_commands, n_writes, n_settings + 1);
        $display("clamped widths %0d, narrow five-digit fields %0d",
                 n_clamped, n_narrow);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
